[design/pid_line_follow_steering_top_assert.svh]
// ----------------------------------------------------------------------------
// pid line follow steering assertion macros
// concurrent check templates shared by the steering block
// ----------------------------------------------------------------------------
`ifndef PID_LINE_FOLLOW_STEERING_TOP_ASSERT_SVH
`define PID_LINE_FOLLOW_STEERING_TOP_ASSERT_SVH

// same-cycle implication under async active-low reset
`define PLFS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under async active-low reset
`define PLFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/plfs_pkg.sv]
// ----------------------------------------------------------------------------
// plfs_pkg
// types, register codes and helpers for the line follow steering block
// ----------------------------------------------------------------------------
package plfs_pkg;

	localparam int IMAGE_WIDTH = 64;
	localparam int COL_W       = 6;
	localparam int SPEED_W     = 16;
	localparam int BASE_W      = 15;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	typedef logic [COL_W-1:0]          col_t;
	typedef logic signed [SPEED_W-1:0] speed_t;
	typedef logic [BASE_W-1:0]         base_t;

	// register index codes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PROP_GAIN     = 3'd0,
		CFG_INTEGRAL_GAIN = 3'd1,
		CFG_DERIV_GAIN    = 3'd2,
		CFG_CENTER_COLUMN = 3'd3,
		CFG_DEADBAND      = 3'd4,
		CFG_BASE_FAST     = 3'd5,
		CFG_BASE_SLOW     = 3'd6
	} cfg_idx_t;

	localparam col_t  CENTER_RESET    = 6'd32;
	localparam col_t  DEADBAND_RESET  = 6'd2;
	localparam base_t BASE_FAST_RESET = 15'd2304;
	localparam base_t BASE_SLOW_RESET = 15'd1792;

	// columns past the image edge pin to the last column
	function automatic col_t clamp_col(input col_t c);
		logic [12:0] wide;
		wide = {7'd0, c};
		if (wide >= 13'(IMAGE_WIDTH))
			return COL_W'(IMAGE_WIDTH - 1);
		else
			return c;
	endfunction

	// 17-bit signed to 16-bit signed with saturation
	function automatic speed_t sat17(input logic signed [16:0] v);
		if (v[16] != v[15])
			return v[16] ? 16'sh8000 : 16'sh7fff;
		else
			return v[15:0];
	endfunction

endpackage

[design/pid_line_follow_steering_top.sv]
// ----------------------------------------------------------------------------
// pid_line_follow_steering_top
// pid steering of a two-wheel robot from the camera column of a line
// ----------------------------------------------------------------------------
// usage
//   in channel : in_valid / in_stall carry one item, the line column
//   out channel: out_valid / out_stall carry left_speed and right_speed
//   cfg port   : cfg_wr_en, cfg_index, cfg_data write gains, center,
//                deadband and base speeds; write only while idle
// timing
//   an accepted item lands in the input register, the pid math runs in
//   one pass from there into the result register: out_valid rises one
//   cycle after the accepting edge, one item per cycle sustained
//   the pid state (last output, last error, integral) updates as each
//   item moves into the result register, so consecutive items chain
// stall
//   a stalled result holds in the result register; the input register
//   keeps taking items until it too is full, then in_stall rises
// reset
//   arst_n clears the state, empties both registers and loads the
//   register reset values
// ----------------------------------------------------------------------------
`include "pid_line_follow_steering_top_assert.svh"

module pid_line_follow_steering_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input channel
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  plfs_pkg::col_t                        line_column,
	// output channel
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output plfs_pkg::speed_t                      left_speed,
	output plfs_pkg::speed_t                      right_speed,
	// configuration
	input  logic                                  cfg_wr_en,
	input  logic [plfs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [plfs_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import plfs_pkg::*;

	// configuration registers
	logic signed [15:0] kp_q, ki_q, kd_q;
	col_t               center_q, deadband_q;
	base_t              base_fast_q, base_slow_q;

	// pid state
	speed_t             prev_output_q, prev_error_q;
	logic signed [31:0] error_sum_q;

	// input register
	logic               valid_s1;
	col_t               col_s1;

	// result register
	logic               valid_s2;
	speed_t             left_s2, right_s2;

	logic               s2_free, advance;

	// combinational pid pass
	col_t               col_c, cen_c;
	logic signed [6:0]  offset_c;
	logic signed [16:0] err_wide_c;
	speed_t             err_c;
	logic signed [32:0] sum_wide_c;
	logic signed [31:0] sum_nx_c;
	logic signed [16:0] diff_c;
	logic signed [31:0] prod_p_c;
	logic signed [47:0] prod_i_c;
	logic signed [32:0] prod_d_c;
	logic signed [49:0] acc_c;
	speed_t             out_c, half_c;
	logic [6:0]         mag_wide_c;
	base_t              base_c;
	logic signed [16:0] left_wide_c, right_wide_c;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q        <= '0;
			ki_q        <= '0;
			kd_q        <= '0;
			center_q    <= CENTER_RESET;
			deadband_q  <= DEADBAND_RESET;
			base_fast_q <= BASE_FAST_RESET;
			base_slow_q <= BASE_SLOW_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_PROP_GAIN:     kp_q        <= cfg_data;
				CFG_INTEGRAL_GAIN: ki_q        <= cfg_data;
				CFG_DERIV_GAIN:    kd_q        <= cfg_data;
				CFG_CENTER_COLUMN: center_q    <= cfg_data[COL_W-1:0];
				CFG_DEADBAND:      deadband_q  <= cfg_data[COL_W-1:0];
				CFG_BASE_FAST:     base_fast_q <= cfg_data[BASE_W-1:0];
				CFG_BASE_SLOW:     base_slow_q <= cfg_data[BASE_W-1:0];
				default: ;
			endcase
		end
	end

	// flow control: the result register frees when empty or taken
	assign s2_free  = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && s2_free;
	assign in_stall = valid_s1 && !s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			col_s1 <= line_column;
		end
	end

	// pid pass from input register state into result register
	always_comb begin
		col_c    = clamp_col(col_s1);
		cen_c    = clamp_col(center_q);
		offset_c = $signed({1'b0, col_c}) - $signed({1'b0, cen_c});

		// target in q8.8 minus fed back output
		err_wide_c = $signed({{2{offset_c[6]}}, offset_c, 8'h00})
			- $signed({prev_output_q[15], prev_output_q});
		err_c = sat17(err_wide_c);

		// saturating integral
		sum_wide_c = $signed({error_sum_q[31], error_sum_q})
			+ $signed({{17{err_c[15]}}, err_c});
		if (sum_wide_c[32] != sum_wide_c[31])
			sum_nx_c = sum_wide_c[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		else
			sum_nx_c = sum_wide_c[31:0];

		diff_c = $signed({err_c[15], err_c}) - $signed({prev_error_q[15], prev_error_q});

		prod_p_c = err_c * kp_q;
		prod_i_c = sum_nx_c * ki_q;
		prod_d_c = diff_c * kd_q;

		// q16.16 sum, round half up back to q8.8
		acc_c = 50'(prod_p_c) + 50'(prod_i_c) + 50'(prod_d_c) + 50'sd128;
		if (acc_c[49:23] != {27{acc_c[49]}})
			out_c = acc_c[49] ? 16'sh8000 : 16'sh7fff;
		else
			out_c = acc_c[23:8];

		half_c = {out_c[15], out_c[15:1]};

		// fast base inside the deadband around center
		mag_wide_c = offset_c[6] ? 7'(-offset_c) : 7'(offset_c);
		base_c     = (mag_wide_c[COL_W-1:0] <= deadband_q) ? base_fast_q : base_slow_q;

		left_wide_c  = $signed({2'b00, base_c}) + $signed({half_c[15], half_c});
		right_wide_c = $signed({2'b00, base_c}) - $signed({half_c[15], half_c});
	end

	// pid state moves with the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_output_q <= '0;
			prev_error_q  <= '0;
			error_sum_q   <= '0;
		end else if (advance) begin
			prev_output_q <= out_c;
			prev_error_q  <= err_c;
			error_sum_q   <= sum_nx_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			left_s2  <= sat17(left_wide_c);
			right_s2 <= sat17(right_wide_c);
		end
	end

	assign out_valid   = valid_s2;
	assign left_speed  = left_s2;
	assign right_speed = right_s2;

	// checks
	`PLFS_ASSERT_NEXT(a_state_only_on_advance, clk, arst_n, !advance,
		$stable(prev_output_q) && $stable(prev_error_q) && $stable(error_sum_q),
		"pid state changed without an item moving")
	`PLFS_ASSERT_NEXT(a_no_item_lost, clk, arst_n, valid_s1 && valid_s2 && out_stall,
		valid_s1 && valid_s2, "item dropped while output stalled")
	`PLFS_ASSERT_NEXT(a_advance_makes_result, clk, arst_n, advance,
		valid_s2 && out_valid, "advanced item did not reach result register")

endmodule
